// File: src/gpe_pkg.sv
package gpe_pkg;

	localparam int PORT_WIDTH = 8;
	localparam logic [PORT_WIDTH-1:0] CHANGE_BITS = PORT_WIDTH'(8'hf0);
	localparam logic INT_RISING_EDGE_RST = 1'b1;

	typedef enum logic [1:0] {
		FUNC_WR_PORT = 2'd0,
		FUNC_WR_DIR  = 2'd1,
		FUNC_RD_PORT = 2'd2,
		FUNC_PIN_CHG = 2'd3
	} func_t;

	typedef enum logic {
		REG_INT_RISING_EDGE = 1'b0,
		REG_DRIVEN_PIN_MASK = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                  int_rising_edge;
		logic [PORT_WIDTH-1:0] driven_pin_mask;
	} cfg_t;

	typedef struct packed {
		logic [PORT_WIDTH-1:0] pin_value;
		logic [PORT_WIDTH-1:0] write_latch;
		logic [PORT_WIDTH-1:0] direction;
	} port_state_t;

	typedef struct packed {
		func_t                 func;
		logic [PORT_WIDTH-1:0] wdata;
		logic [2:0]            pin_index;
		logic [PORT_WIDTH-1:0] ext_levels;
	} access_t;

	typedef struct packed {
		logic [PORT_WIDTH-1:0] read_data;
		logic [PORT_WIDTH-1:0] dir_out;
		logic                  edge_irq;
		logic                  change_irq;
	} result_t;

endpackage

// File: src/gpe_cfg.sv
module gpe_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [7:0]               cfg_wdata,
	output gpe_pkg::cfg_t            cfg
);

	gpe_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.int_rising_edge <= gpe_pkg::INT_RISING_EDGE_RST;
			cfg_q.driven_pin_mask <= '0;
		end else if (cfg_we) begin
			case (gpe_pkg::reg_idx_t'(cfg_index))
				gpe_pkg::REG_INT_RISING_EDGE: cfg_q.int_rising_edge <= cfg_wdata[0];
				gpe_pkg::REG_DRIVEN_PIN_MASK:
					cfg_q.driven_pin_mask <= cfg_wdata[gpe_pkg::PORT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/gpe_access.sv
module gpe_access (
	input  gpe_pkg::access_t     acc,
	input  gpe_pkg::cfg_t        cfg,
	input  gpe_pkg::port_state_t cur,
	output gpe_pkg::port_state_t nxt,
	output gpe_pkg::result_t     res
);

	logic [gpe_pkg::PORT_WIDTH-1:0] prior;
	logic [gpe_pkg::PORT_WIDTH-1:0] flip;
	logic [gpe_pkg::PORT_WIDTH-1:0] take;
	logic [gpe_pkg::PORT_WIDTH-1:0] diff;

	always_comb begin
		nxt    = cur;
		prior  = cur.pin_value;
		flip   = cur.direction ^ acc.wdata;
		take   = cfg.driven_pin_mask & cur.direction;
		case (acc.func)
			gpe_pkg::FUNC_WR_PORT: begin
				nxt.write_latch = acc.wdata;
				nxt.pin_value   = acc.wdata;
			end
			gpe_pkg::FUNC_WR_DIR: begin
				prior           = (cur.pin_value & ~flip) | (cur.write_latch & flip);
				nxt.direction   = acc.wdata;
				nxt.pin_value   = cur.write_latch;
			end
			gpe_pkg::FUNC_RD_PORT: begin
				nxt.pin_value   = (cur.pin_value & ~take) | (acc.ext_levels & take);
			end
			gpe_pkg::FUNC_PIN_CHG: begin
				if (32'(acc.pin_index) < gpe_pkg::PORT_WIDTH) begin
					nxt.pin_value[acc.pin_index] = acc.wdata[0];
				end
			end
			default: ;
		endcase
	end

	assign diff           = prior ^ nxt.pin_value;
	assign res.read_data  = nxt.pin_value;
	assign res.dir_out    = nxt.direction;
	assign res.edge_irq   = diff[0] && (nxt.pin_value[0] == cfg.int_rising_edge);
	assign res.change_irq = |(diff & gpe_pkg::CHANGE_BITS & nxt.direction);

endmodule

// File: src/gpio_port_edge_interrupt.sv
// 8-bit I/O port with a bit 0 edge interrupt and a change interrupt on bits 4 to 7.
//
// input channel: in_valid/in_ready carry one access beat (func, wdata, pin_index,
// ext_levels). func selects write port, write direction, read port or an
// external change to the pin given by pin_index.
// output channel: out_valid/out_ready carry one result beat per access: the pin
// value and direction after the access plus the two interrupt flags.
// configuration: cfg_we writes cfg_wdata into register cfg_index (0 edge select,
// 1 driven pin mask) on the same edge; write only while no access is in flight.
//
// path: the input register holds the access, then the result register the result.
// throughput: one access per cycle unless a held result stalls; the state update is
// one level of bitwise logic between the input register and the result register.
// reset: pins, latch and direction clear, edge select goes to rising, mask clears,
// both channels empty.
// stall: a held result keeps the result register; one more beat waits in the
// input register and in_ready drops until the result is taken.
module gpio_port_edge_interrupt (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] wdata,
	input  logic [2:0] pin_index,
	input  logic [7:0] ext_levels,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic [7:0] dir_out,
	output logic       edge_irq,
	output logic       change_irq
);

	gpe_pkg::cfg_t        cfg;
	gpe_pkg::access_t     acc_s1;
	logic                 valid_s1;
	gpe_pkg::port_state_t state_q;
	gpe_pkg::port_state_t state_nxt;
	gpe_pkg::result_t     res_nxt;
	gpe_pkg::result_t     res_q;
	logic                 out_valid_q;
	logic                 advance;

	gpe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	gpe_access u_access (
		.acc (acc_s1),
		.cfg (cfg),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			acc_s1.func       <= gpe_pkg::func_t'(func);
			acc_s1.wdata      <= wdata[gpe_pkg::PORT_WIDTH-1:0];
			acc_s1.pin_index  <= pin_index;
			acc_s1.ext_levels <= ext_levels[gpe_pkg::PORT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = 8'(res_q.read_data);
	assign dir_out    = 8'(res_q.dir_out);
	assign edge_irq   = res_q.edge_irq;
	assign change_irq = res_q.change_irq;

endmodule

// File: src/gpe_checker.sv
module gpe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_data,
	input logic [7:0] dir_out,
	input logic       edge_irq,
	input logic       change_irq
);

	// held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(dir_out)
			&& $stable(edge_irq) && $stable(change_irq))
		else $error("result beat changed while stalled");

	// input side only backs up behind a stalled result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without output stall");

	// change interrupt needs an input pin among the upper bits
	a_change_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && change_irq |-> (dir_out[7:4] != 4'b0000))
		else $error("change interrupt with no upper input pin");

	// an in-flight beat keeps the output busy once the stage is full
	a_in_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_valid && !out_ready |=> !in_ready || out_valid)
		else $error("beat lost behind stalled result");

endmodule

bind gpio_port_edge_interrupt gpe_checker u_gpe_checker (.*);

// File: verif/gpio_port_edge_interrupt_tb.sv
`timescale 1ns / 1ps

module gpio_port_edge_interrupt_tb;

	localparam int HOLD_OFF_CYCLES = 200;
	localparam int DRAIN_CYCLES    = 4;
	localparam int BATCH_ITEMS     = 300;
	localparam longint TIMEOUT_NS  = 5_000_000;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       cfg_we     = 1'b0;
	logic       cfg_index  = 1'b0;
	logic [7:0] cfg_wdata  = 8'h00;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [1:0] func       = 2'd0;
	logic [7:0] wdata      = 8'h00;
	logic [2:0] pin_index  = 3'd0;
	logic [7:0] ext_levels = 8'h00;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic [7:0] read_data;
	logic [7:0] dir_out;
	logic       edge_irq;
	logic       change_irq;

	// port state as the block should hold it
	logic [7:0] pin_q   = 8'h00;
	logic [7:0] latch_q = 8'h00;
	logic [7:0] dir_q   = 8'h00;
	logic       rising_q = gpe_pkg::INT_RISING_EDGE_RST;
	logic [7:0] mask_q   = 8'h00;

	gpe_pkg::access_t pending_accesses[$];
	gpe_pkg::result_t expected_results[$];
	gpe_pkg::access_t next_access;
	gpe_pkg::result_t want;

	int  src_idle_pct  = 0;
	int  snk_stall_pct = 0;
	bit  in_beat_taken = 1'b0;
	bit  hold_off_req  = 1'b0;
	bit  hold_off_done = 1'b0;
	int  hold_left     = 0;
	int  errors        = 0;
	int  accesses_taken = 0;
	int  results_checked = 0;
	int  edge_seen     = 0;
	int  change_seen   = 0;

	gpio_port_edge_interrupt dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic gpe_pkg::result_t predict_port_access(gpe_pkg::access_t a);
		logic [7:0] prior;
		logic [7:0] flip;
		logic [7:0] take;
		logic [7:0] delta;
		gpe_pkg::result_t r;
		prior = pin_q;
		case (a.func)
			gpe_pkg::FUNC_WR_PORT: begin
				latch_q = a.wdata;
				pin_q   = a.wdata;
			end
			gpe_pkg::FUNC_WR_DIR: begin
				// flipped pins pick up the latch, then the port is rewritten from it
				flip  = dir_q ^ a.wdata;
				pin_q = (pin_q & ~flip) | (latch_q & flip);
				dir_q = a.wdata;
				prior = pin_q;
				pin_q = latch_q;
			end
			gpe_pkg::FUNC_RD_PORT: begin
				take  = mask_q & dir_q;
				pin_q = (pin_q & ~take) | (a.ext_levels & take);
			end
			default: begin
				pin_q[a.pin_index] = a.wdata[0];
			end
		endcase
		delta        = prior ^ pin_q;
		r.read_data  = pin_q;
		r.dir_out    = dir_q;
		r.edge_irq   = delta[0] && (pin_q[0] == rising_q);
		r.change_irq = |(delta & gpe_pkg::CHANGE_BITS & dir_q);
		return r;
	endfunction

	// sender
	always @(negedge clk) begin
		if (!in_valid || in_beat_taken) begin
			if (pending_accesses.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				next_access = pending_accesses.pop_front();
				in_valid   <= 1'b1;
				func       <= next_access.func;
				wdata      <= next_access.wdata;
				pin_index  <= next_access.pin_index;
				ext_levels <= next_access.ext_levels;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off on request
	always @(negedge clk) begin
		if (hold_off_req && !hold_off_done) begin
			hold_left     <= HOLD_OFF_CYCLES;
			hold_off_done <= 1'b1;
			out_ready     <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		in_beat_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			expected_results.push_back(predict_port_access(
				gpe_pkg::access_t'{gpe_pkg::func_t'(func), wdata, pin_index, ext_levels}));
			accesses_taken++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: read_data %02h dir_out %02h",
					read_data, dir_out);
				errors++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				edge_seen   += want.edge_irq;
				change_seen += want.change_irq;
				if (read_data !== want.read_data) begin
					$error("read_data: expected %02h, got %02h", want.read_data, read_data);
					errors++;
				end
				if (dir_out !== want.dir_out) begin
					$error("dir_out: expected %02h, got %02h", want.dir_out, dir_out);
					errors++;
				end
				if (edge_irq !== want.edge_irq) begin
					$error("edge_irq: expected %0b, got %0b", want.edge_irq, edge_irq);
					errors++;
				end
				if (change_irq !== want.change_irq) begin
					$error("change_irq: expected %0b, got %0b", want.change_irq, change_irq);
					errors++;
				end
			end
		end
	end

	task automatic queue_access(gpe_pkg::func_t f, logic [7:0] w, logic [2:0] p,
		logic [7:0] e);
		pending_accesses.push_back(gpe_pkg::access_t'{f, w, p, e});
	endtask

	task automatic queue_random_accesses(int n);
		int pick;
		gpe_pkg::func_t f;
		logic [7:0] w;
		logic [2:0] p;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 25)
				f = gpe_pkg::FUNC_WR_PORT;
			else if (pick < 45)
				f = gpe_pkg::FUNC_WR_DIR;
			else if (pick < 70)
				f = gpe_pkg::FUNC_RD_PORT;
			else
				f = gpe_pkg::FUNC_PIN_CHG;
			w = $urandom_range(255);
			if (f == gpe_pkg::FUNC_WR_DIR && $urandom_range(3) == 0) begin
				case ($urandom_range(2))
					0: w = 8'h00;
					1: w = 8'hff;
					default: w = 8'hf0;
				endcase
			end
			// bit 0 carries the edge interrupt, so lean on it
			p = ($urandom_range(9) < 3) ? 3'd0 : 3'($urandom_range(7));
			queue_access(f, w, p, 8'($urandom_range(255)));
		end
	endtask

	task automatic drain;
		while (pending_accesses.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(gpe_pkg::reg_idx_t idx, logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == gpe_pkg::REG_INT_RISING_EDGE)
			rising_q = val[0];
		else
			mask_q = val;
	endtask

	task automatic run_batch(int src_pct, int snk_pct, logic rising, logic [7:0] mask);
		write_cfg(gpe_pkg::REG_INT_RISING_EDGE, {7'd0, rising});
		write_cfg(gpe_pkg::REG_DRIVEN_PIN_MASK, mask);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		queue_random_accesses(BATCH_ITEMS);
		drain();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default settings: rising edge, no driven pins
		src_idle_pct  = 30;
		snk_stall_pct = 52;
		queue_access(gpe_pkg::FUNC_WR_PORT, 8'hff, 3'd0, 8'h00);
		queue_access(gpe_pkg::FUNC_WR_PORT, 8'h00, 3'd7, 8'hff);
		queue_access(gpe_pkg::FUNC_WR_DIR,  8'hff, 3'd0, 8'h00);
		queue_access(gpe_pkg::FUNC_PIN_CHG, 8'h01, 3'd0, 8'h00);
		queue_access(gpe_pkg::FUNC_PIN_CHG, 8'h01, 3'd7, 8'h00);
		queue_access(gpe_pkg::FUNC_PIN_CHG, 8'hff, 3'd4, 8'h00);
		queue_access(gpe_pkg::FUNC_PIN_CHG, 8'h01, 3'd3, 8'h00);
		queue_access(gpe_pkg::FUNC_RD_PORT, 8'h00, 3'd0, 8'hff);
		queue_access(gpe_pkg::FUNC_WR_PORT, 8'ha5, 3'd0, 8'h00);
		queue_access(gpe_pkg::FUNC_WR_DIR,  8'h0f, 3'd0, 8'h00);
		queue_access(gpe_pkg::FUNC_PIN_CHG, 8'hfe, 3'd0, 8'hff);
		queue_access(gpe_pkg::FUNC_WR_DIR,  8'h00, 3'd0, 8'h00);
		drain();

		// falling edge, every pin driven
		write_cfg(gpe_pkg::REG_INT_RISING_EDGE, 8'h00);
		write_cfg(gpe_pkg::REG_DRIVEN_PIN_MASK, 8'hff);
		queue_access(gpe_pkg::FUNC_WR_DIR,  8'hff, 3'd0, 8'h00);
		queue_access(gpe_pkg::FUNC_RD_PORT, 8'h00, 3'd0, 8'h00);
		queue_access(gpe_pkg::FUNC_RD_PORT, 8'h00, 3'd0, 8'hff);
		queue_access(gpe_pkg::FUNC_RD_PORT, 8'h00, 3'd0, 8'h00);
		queue_access(gpe_pkg::FUNC_PIN_CHG, 8'h00, 3'd6, 8'h00);
		queue_access(gpe_pkg::FUNC_WR_DIR,  8'hf0, 3'd0, 8'hff);
		queue_access(gpe_pkg::FUNC_RD_PORT, 8'h00, 3'd0, 8'h5a);
		queue_access(gpe_pkg::FUNC_WR_PORT, 8'h01, 3'd0, 8'h00);
		queue_access(gpe_pkg::FUNC_PIN_CHG, 8'h00, 3'd0, 8'h00);
		queue_access(gpe_pkg::FUNC_RD_PORT, 8'hff, 3'd7, 8'hff);
		drain();

		run_batch(30, 52, 1'b0, 8'hff);
		run_batch(30, 52, 1'b1, 8'($urandom_range(255)));
		run_batch(52, 30, 1'b0, 8'h00);
		run_batch(52, 30, 1'b1, 8'($urandom_range(255)));
		hold_off_req = 1'b1;
		run_batch(0, 0, 1'($urandom_range(1)), 8'hff);
		run_batch(0, 0, 1'($urandom_range(1)), 8'($urandom_range(255)));

		$display("covered %0d accesses of all four kinds over eight register settings,",
			accesses_taken);
		$display("%0d results checked, %0d edge and %0d change interrupts among them",
			results_checked, edge_seen, change_seen);
		if (errors == 0) begin
			$display("gpio_port_edge_interrupt_tb: done, clean");
		end else begin
			$display("gpio_port_edge_interrupt_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("gpio_port_edge_interrupt_tb: done, errors");
		$finish;
	end

endmodule
